FILE: design/eps_pkg.sv
// Shared types, constants and the exp2 lookup table for the square oscillator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package eps_pkg;

	// Field and register widths.
	localparam int CV_W      = 17;
	localparam int WAVE_W    = 16;
	localparam int KNOB_W    = 13;
	localparam int STEP_W    = 23;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = STEP_W;

	// Oscillator sizing.
	localparam int PHASE_BITS        = 32;
	localparam int EXP_TABLE_ENTRIES = 64;
	localparam int FRAC_BITS         = 12;
	localparam int SEG_W             = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int EXP_W             = 32;
	localparam int OCT_W             = 4;
	localparam int U_W               = 16;
	localparam int SUM_W             = 18;
	localparam int MUL_W             = 32;
	localparam int PROD_W            = 2 * MUL_W;
	localparam int SHAMT_W           = 6;
	localparam int INC_SHIFT         = 48 - PHASE_BITS;
	localparam int TAYLOR_TERMS      = 15;

	// Fixed-point constants.
	localparam logic signed [SUM_W-1:0] PITCH_MAX  = 18'sd16384;
	localparam logic signed [SUM_W-1:0] PITCH_MIN  = -18'sd16384;
	localparam logic [SHAMT_W-1:0]      FREQ_SHIFT = 6'd34;
	localparam logic [MUL_W-1:0]        C4_Q16     = 32'd17146024;
	localparam logic [63:0]             LN2_Q30    = 64'd744261118;
	localparam logic [63:0]             ONE_Q30    = 64'd1073741824;
	localparam logic signed [WAVE_W-1:0] LEVEL_HIGH = 16'sd20480;
	localparam logic signed [WAVE_W-1:0] LEVEL_LOW  = -16'sd20480;

	// Register reset values.
	localparam logic [KNOB_W-1:0] KNOB_RESET = '0;
	localparam logic [STEP_W-1:0] STEP_RESET = 23'd89478;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KNOB_PITCH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd1;

	typedef logic signed [CV_W-1:0]   cv_t;
	typedef logic signed [WAVE_W-1:0] wave_t;
	typedef logic [EXP_TABLE_ENTRIES:0][EXP_W-1:0] exp_rom_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TABLE,
		ST_INTERP,
		ST_MANT,
		ST_FREQ,
		ST_SHIFT,
		ST_INC,
		ST_COMMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MUL_INTERP,
		MUL_FREQ,
		MUL_INC
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     rom_ld;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     mant_ld;
		logic     freq_ld;
		logic     commit;
	} dp_cmd_t;

	// Division of a Taylor term by its index, one literal divisor per arm.
	function automatic logic [63:0] div_by_term(input logic [63:0] v, input int unsigned i);
		case (i)
			1:  return v / 1;
			2:  return v / 2;
			3:  return v / 3;
			4:  return v / 4;
			5:  return v / 5;
			6:  return v / 6;
			7:  return v / 7;
			8:  return v / 8;
			9:  return v / 9;
			10: return v / 10;
			11: return v / 11;
			12: return v / 12;
			13: return v / 13;
			14: return v / 14;
			15: return v / 15;
			default: return v;
		endcase
	endfunction

	// Table of 2^(k/N) in Q2.30, built by an integer Taylor series of e^(x*ln2).
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		rom = '0;
		for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
			x    = (64'(k) << 30) / EXP_TABLE_ENTRIES;
			y    = (x * LN2_Q30) >> 30;
			term = ONE_Q30;
			sum  = ONE_Q30;
			for (int unsigned i = 1; i <= TAYLOR_TERMS; i++) begin
				term = div_by_term((term * y) >> 30, i);
				sum  = sum + term;
			end
			rom[k] = sum[EXP_W-1:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: design/eps_if.sv
// Valid/ready stream interfaces for the control-voltage input and the wave output.
// Depends on eps_pkg for the payload types.
`timescale 1ns / 1ps

interface eps_cv_if import eps_pkg::*; ();
	logic valid;
	logic ready;
	cv_t  cv_volts;

	modport source (output valid, output cv_volts, input ready);
	modport sink (input valid, input cv_volts, output ready);
	modport monitor (input valid, input cv_volts, input ready);
endinterface

interface eps_wave_if import eps_pkg::*; ();
	logic  valid;
	logic  ready;
	wave_t wave_level;

	modport source (output valid, output wave_level, input ready);
	modport sink (input valid, input wave_level, output ready);
	modport monitor (input valid, input wave_level, input ready);
endinterface

FILE: design/eps_ctrl.sv
// Sequencing state machine for the oscillator: steps one word through the datapath.
// Depends on eps_pkg for the state and command types.
`timescale 1ns / 1ps

module eps_ctrl import eps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        commit_fire;

	// The result slot is free when empty or being emptied this cycle.
	assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_TABLE;
			ST_TABLE:  state_d = ST_INTERP;
			ST_INTERP: state_d = ST_MANT;
			ST_MANT:   state_d = ST_FREQ;
			ST_FREQ:   state_d = ST_SHIFT;
			ST_SHIFT:  state_d = ST_INC;
			ST_INC:    state_d = ST_COMMIT;
			ST_COMMIT: if (commit_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = MUL_INTERP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_TABLE:  cmd.rom_ld = 1'b1;
			ST_INTERP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTERP;
			end
			ST_MANT:   cmd.mant_ld = 1'b1;
			ST_FREQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FREQ;
			end
			ST_SHIFT:  cmd.freq_ld = 1'b1;
			ST_INC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INC;
			end
			ST_COMMIT: cmd.commit = commit_fire;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/eps_dp.sv
// Datapath of the oscillator: pitch clamp, exp2 table and interpolation, one shared
// multiplier, octave shift and the phase accumulator. Depends on eps_pkg.
`timescale 1ns / 1ps

module eps_dp import eps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  cv_t                  cv_volts,
	input  dp_cmd_t              cmd,
	output wave_t                wave_level
);

	logic [KNOB_W-1:0]       knob_q;
	logic [STEP_W-1:0]       step_q;
	logic [PHASE_BITS-1:0]   phase_q;

	logic [OCT_W-1:0]        oct_q;
	logic [FRAC_BITS-1:0]    frac_q;
	logic [FRAC_BITS-1:0]    rem_q;
	logic [EXP_W-1:0]        e_lo_q;
	logic [EXP_W-1:0]        diff_q;
	logic [MUL_W-1:0]        mant_q;
	logic [MUL_W-1:0]        freq_q;
	logic [PROD_W-1:0]       prod_q;
	wave_t                   wave_q;

	logic signed [SUM_W-1:0] pitch_sum;
	logic signed [SUM_W-1:0] pitch_clamped;
	logic [SUM_W-1:0]        u_full;
	logic [FRAC_BITS+SEG_W-1:0] seg_scaled;
	logic [SEG_W-1:0]        seg;
	logic [SEG_W-1:0]        seg_next;
	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [SHAMT_W-1:0]      shamt;
	logic [PROD_W-1:0]       prod_shifted;
	logic [PHASE_BITS-1:0]   phase_next;

	// Pitch: knob plus control voltage, saturated to four volts each way.
	always_comb begin
		pitch_sum = $signed({{(SUM_W-KNOB_W){1'b0}}, knob_q})
			+ $signed({{(SUM_W-CV_W){cv_volts[CV_W-1]}}, cv_volts});
		if (pitch_sum > PITCH_MAX) begin
			pitch_clamped = PITCH_MAX;
		end else if (pitch_sum < PITCH_MIN) begin
			pitch_clamped = PITCH_MIN;
		end else begin
			pitch_clamped = pitch_sum;
		end
		u_full = $unsigned(pitch_clamped - PITCH_MIN);
	end

	// Table segment and interpolation weight from the octave fraction.
	always_comb begin
		seg_scaled = {{SEG_W{1'b0}}, frac_q} * (FRAC_BITS+SEG_W)'(EXP_TABLE_ENTRIES);
		seg        = seg_scaled[FRAC_BITS +: SEG_W];
		seg_next   = seg + SEG_W'(1);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MUL_INTERP: begin
				mul_a = diff_q;
				mul_b = {{(MUL_W-FRAC_BITS){1'b0}}, rem_q};
			end
			MUL_FREQ: begin
				mul_a = mant_q;
				mul_b = C4_Q16;
			end
			MUL_INC: begin
				mul_a = freq_q;
				mul_b = {{(MUL_W-STEP_W){1'b0}}, step_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign shamt        = FREQ_SHIFT - {{(SHAMT_W-OCT_W){1'b0}}, oct_q};
	assign prod_shifted = prod_q >> shamt;
	assign phase_next   = phase_q + prod_q[INC_SHIFT +: PHASE_BITS];

	// Configuration registers and phase state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_q  <= KNOB_RESET;
			step_q  <= STEP_RESET;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KNOB_PITCH: knob_q <= cfg_wdata[KNOB_W-1:0];
					REG_PHASE_STEP: step_q <= cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				phase_q <= phase_next;
			end
		end
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			oct_q  <= u_full[FRAC_BITS +: OCT_W];
			frac_q <= u_full[FRAC_BITS-1:0];
		end
		if (cmd.rom_ld) begin
			rem_q  <= seg_scaled[FRAC_BITS-1:0];
			e_lo_q <= EXP_ROM[seg];
			diff_q <= EXP_ROM[seg_next] - EXP_ROM[seg];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mant_ld) begin
			mant_q <= e_lo_q + prod_q[FRAC_BITS +: MUL_W];
		end
		if (cmd.freq_ld) begin
			freq_q <= prod_shifted[MUL_W-1:0];
		end
		if (cmd.commit) begin
			wave_q <= phase_next[PHASE_BITS-1] ? LEVEL_LOW : LEVEL_HIGH;
		end
	end

	assign wave_level = wave_q;

endmodule

FILE: design/exp_pitch_square_oscillator_top.sv
// Top level of the exponential-pitch square oscillator.
// Depends on eps_pkg, eps_if, eps_ctrl and eps_dp.
`timescale 1ns / 1ps

// Usage
// Each word on the cv channel is one sample tick carrying a control voltage in
// volts with 12 fraction bits. The block adds the knob_pitch register, clamps the
// pitch to plus or minus 4 V, and forms 261.6276 * 2^pitch Hz with an interpolated
// exp2 table and an octave shift. The frequency times phase_step_per_hz advances a
// 32-bit phase accumulator, and each tick returns one word on the wave channel:
// +5 V while the new phase is non-negative, -5 V otherwise.
// After acceptance a word walks the table, interpolate, mantissa, frequency,
// shift, increment and commit states, then wave.valid rises. The block handles
// one word at a time, taking a new one only once the last is committed: the
// controller walks it through the single shared 32 x 32 multiplier, thrice per word.
// The wave output is a register, so cv.ready returns as soon as a result is in it,
// even if the receiver has not yet taken that result. If the receiver stalls
// longer, the next result waits in the final step and cv.ready stays low.
// Reset clears the phase, sets knob_pitch to 0 and phase_step_per_hz to 89478
// (a 48 kHz sample rate), and leaves the wave channel empty. Configuration writes
// take effect at once and should be made while no word is in flight.

module exp_pitch_square_oscillator_top import eps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	eps_cv_if.sink               cv,
	eps_wave_if.source           wave
);

	dp_cmd_t cmd;

	// The controller owns the handshakes and the result-valid flag.
	eps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv.valid),
		.in_ready  (cv.ready),
		.out_valid (wave.valid),
		.out_ready (wave.ready),
		.cmd       (cmd)
	);

	// The datapath holds the registers, the phase and the result word.
	eps_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cv_volts   (cv.cv_volts),
		.cmd        (cmd),
		.wave_level (wave.wave_level)
	);

endmodule

FILE: design/eps_checker.sv
// Port-level checks for the square oscillator, bound to the top level.
// Depends on eps_pkg for the level constants and the wave type.
`timescale 1ns / 1ps

module eps_checker import eps_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cv_valid,
	input logic  cv_ready,
	input logic  wave_valid,
	input logic  wave_ready,
	input wave_t wave_level
);

	// A valid result is always one of the two square levels.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		wave_valid |-> (wave_level == LEVEL_HIGH || wave_level == LEVEL_LOW))
		else $error("wave level is not a square level");

	// One word at a time: the input closes right after an accept.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cv_valid && cv_ready) |=> !cv_ready)
		else $error("input ready after accept");

	// A new result never appears while the input was open in the previous cycle.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wave_valid) |-> !$past(cv_ready))
		else $error("result appeared without a word in flight");

	// A stalled result holds its level.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(wave_valid && !wave_ready) |=> (wave_valid && $stable(wave_level)))
		else $error("stalled result changed");

endmodule

bind exp_pitch_square_oscillator_top eps_checker u_eps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cv_valid   (cv.valid),
	.cv_ready   (cv.ready),
	.wave_valid (wave.valid),
	.wave_ready (wave.ready),
	.wave_level (wave.wave_level)
);

FILE: verif/eps_square_checker.sv
`timescale 1ns / 1ps
// Checker for the exponential-pitch square oscillator: mirrors the two config
// registers, predicts every wave word from the cv words and compares in order.
// Depends on eps_pkg and the eps_cv_if / eps_wave_if interfaces.

module eps_square_checker import eps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	eps_cv_if.monitor            cv,
	eps_wave_if.monitor          wave,
	output int                   fail_count,
	output int                   pending
);

	localparam int          PITCH_CLAMP   = 16384;
	localparam int          VOLT_FRAC     = 12;
	localparam int          SERIES_TERMS  = 15;
	localparam int          STEP_AT_RESET = 89478;
	localparam logic [63:0] MIDDLE_C_Q16  = 64'd17146024;
	localparam logic [63:0] LN2_Q30_C     = 64'd744261118;
	localparam wave_t       PLUS_FIVE_V   = 16'sd20480;
	localparam wave_t       MINUS_FIVE_V  = -16'sd20480;

	logic [63:0]           exp2_q30 [EXP_TABLE_ENTRIES+1];
	logic [KNOB_W-1:0]     knob_q12;
	logic [STEP_W-1:0]     step_per_hz;
	logic [PHASE_BITS-1:0] phase;
	wave_t                 levels_due [$];
	int                    errors;

	// One point of 2^(k/N) in Q2.30 from a truncated integer series of e^(x*ln2).
	function automatic logic [63:0] exp2_point(input int k);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		x    = (64'(k) << 30) / EXP_TABLE_ENTRIES;
		y    = (x * LN2_Q30_C) >> 30;
		term = 64'd1 << 30;
		sum  = term;
		for (int i = 1; i <= SERIES_TERMS; i++) begin
			term = ((term * y) >> 30) / 64'(i);
			sum  = sum + term;
		end
		return sum;
	endfunction

	initial begin
		for (int k = 0; k <= EXP_TABLE_ENTRIES; k++)
			exp2_q30[k] = exp2_point(k);
	end

	// Advances the phase by one sample tick and returns the level it gives.
	function automatic wave_t advance_phase(input cv_t cv_word);
		int          pitch;
		int unsigned u;
		int unsigned octave;
		int unsigned frac;
		int unsigned seg;
		int unsigned rem;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mant;
		logic [63:0] freq;
		logic [63:0] inc;
		pitch = int'(knob_q12) + int'(cv_word);
		if (pitch > PITCH_CLAMP)
			pitch = PITCH_CLAMP;
		if (pitch < -PITCH_CLAMP)
			pitch = -PITCH_CLAMP;
		u      = pitch + PITCH_CLAMP;
		octave = u >> VOLT_FRAC;
		frac   = u & ((1 << VOLT_FRAC) - 1);
		seg    = (frac * EXP_TABLE_ENTRIES) >> VOLT_FRAC;
		rem    = (frac * EXP_TABLE_ENTRIES) & ((1 << VOLT_FRAC) - 1);
		lo     = exp2_q30[seg];
		hi     = exp2_q30[seg + 1];
		mant   = lo + (((hi - lo) * 64'(rem)) >> VOLT_FRAC);
		freq   = (MIDDLE_C_Q16 * mant) >> (34 - octave);
		inc    = (freq * 64'(step_per_hz)) >> (48 - PHASE_BITS);
		phase  = phase + inc[PHASE_BITS-1:0];
		return phase[PHASE_BITS-1] ? MINUS_FIVE_V : PLUS_FIVE_V;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wave_t wanted;
		if (!arst_n) begin
			knob_q12    = '0;
			step_per_hz = STEP_W'(STEP_AT_RESET);
			phase       = '0;
			levels_due.delete();
			errors      = 0;
		end else begin
			// Results are compared before this edge's cv word is predicted.
			if (wave.valid && wave.ready) begin
				if (levels_due.size() == 0) begin
					errors++;
					$error("wave_level: no word expected, actual %0d", wave.wave_level);
				end else begin
					wanted = levels_due.pop_front();
					if (wave.wave_level !== wanted) begin
						errors++;
						$error("wave_level: expected %0d, actual %0d", wanted,
							wave.wave_level);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KNOB_PITCH: knob_q12 = cfg_wdata[KNOB_W-1:0];
					REG_PHASE_STEP: step_per_hz = cfg_wdata[STEP_W-1:0];
				endcase
			end
			if (cv.valid && cv.ready)
				levels_due.push_back(advance_phase(cv.cv_volts));
		end
		fail_count <= errors;
		pending    <= levels_due.size();
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top of the square oscillator testbench: clock, reset, register writes, cv words
// and wave back-pressure, plus the verdict. Depends on eps_pkg, the eps_if
// interfaces, exp_pitch_square_oscillator_top and eps_square_checker.

module tb import eps_pkg::*;;

	localparam int LONG_HOLD       = 400;
	localparam int DRAIN_CYCLES    = 12;
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 210;
	localparam int KNOB_ONE_VOLT   = 4096;
	localparam int STEP_RANGE_TOP  = 4294967;
	localparam int STEP_DEFAULT    = 89478;
	localparam int PITCH_EDGE      = 16384;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   pending;

	// Knob value as the block holds it, used to aim cv words at the clamp points.
	logic [KNOB_W-1:0] knob_now = '0;
	// When set, neither side inserts gaps.
	bit bursting = 1'b0;
	// A request to the wave receiver to hold off for a long stretch.
	bit hold_wave = 1'b0;

	// Edges of the cv field: zero and its neighbors, octave boundaries, the
	// clamp points with one step either side, the nominal range limits, the
	// full 17-bit extremes and two alternating bit patterns.
	cv_t edge_cvs [18] = '{
		17'sd0, 17'sd1, -17'sd1, 17'sd4095, 17'sd4096, -17'sd4096,
		17'sd16383, 17'sd16384, 17'sd16385, -17'sd16383, -17'sd16384, -17'sd16385,
		17'sd40960, -17'sd40960, 17'h0FFFF, 17'h10000, 17'h15555, 17'h0AAAA
	};

	eps_cv_if   cv_ch ();
	eps_wave_if wave_ch ();

	exp_pitch_square_oscillator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cv        (cv_ch),
		.wave      (wave_ch)
	);

	eps_square_checker square_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cv         (cv_ch),
		.wave       (wave_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (bursting || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Most cv words lie in the nominal +/-10 V range. Some land just around the
	// point where knob plus cv hits the +/-4 V clamp, and the rest use any 17-bit
	// pattern so that every bit of the field toggles.
	function automatic cv_t random_cv();
		int roll;
		int target;
		roll = $urandom_range(99);
		if (roll < 65)
			return cv_t'(int'($urandom_range(81920)) - 40960);
		if (roll < 85) begin
			target = ($urandom_range(1) ? PITCH_EDGE : -PITCH_EDGE) - int'(knob_now);
			return cv_t'(target + int'($urandom_range(128)) - 64);
		end
		return cv_t'($urandom);
	endfunction

	// Knob words mostly stay within 0..1 V. Sometimes a full-width word is
	// written, and the block must drop the bits above the knob's 13.
	function automatic logic [CFG_W-1:0] random_knob_word();
		if ($urandom_range(9) == 0)
			return CFG_W'($urandom);
		return CFG_W'($urandom_range(KNOB_ONE_VOLT));
	endfunction

	// Step words cover the sample-rate range. Small steps give long runs of one
	// level. Full-width steps push the increment past a whole cycle per tick.
	function automatic logic [CFG_W-1:0] random_step_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return CFG_W'($urandom_range(STEP_RANGE_TOP));
		if (roll < 85)
			return CFG_W'($urandom_range(2000));
		return CFG_W'($urandom);
	endfunction

	// Both registers are written on consecutive edges, so the write enable only
	// falls once at the end.
	task automatic set_regs(input logic [CFG_W-1:0] knob_word,
			input logic [CFG_W-1:0] step_word);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KNOB_PITCH;
		cfg_wdata <= knob_word;
		@(posedge clk);
		cfg_index <= REG_PHASE_STEP;
		cfg_wdata <= step_word;
		@(posedge clk);
		cfg_we    <= 1'b0;
		knob_now  = knob_word[KNOB_W-1:0];
	endtask

	// Offers one cv word after a random gap and returns on the edge that takes it.
	// Valid stays high on return so back-to-back words need no extra edge.
	task automatic send_cv(input cv_t value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cv_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cv_ch.valid    <= 1'b1;
		cv_ch.cv_volts <= value;
		do @(posedge clk); while (!cv_ch.ready);
	endtask

	// Stops sending and waits until every predicted wave word has come back,
	// then lets the pipeline settle before anything touches the registers.
	task automatic finish_phase();
		cv_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The wave receiver runs in its own process. After each word it takes, it may
	// drop ready for a random gap. On request it keeps ready low through a hold-off,
	// during which the sender keeps offering words. The output register and the
	// final step then fill up and cv.ready must fall.
	initial begin : wave_receiver
		int gap;
		wave_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_wave) begin
				wave_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_wave = 1'b0;
			end
			wave_ch.ready <= 1'b1;
			do @(posedge clk); while (!wave_ch.valid);
			gap = pick_gap();
			if (gap > 0) begin
				wave_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int half;
		cv_ch.valid    <= 1'b0;
		cv_ch.cv_volts <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_KNOB_PITCH;
		cfg_wdata      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero step right after reset holds the phase at exactly zero. Zero
		// counts as non-negative, so every word must come back as +5 V.
		set_regs('0, '0);
		send_cv(17'sd0);
		send_cv(17'sd40960);
		send_cv(-17'sd40960);
		finish_phase();

		// Field edges at the reset-default step and zero knob.
		set_regs('0, CFG_W'(STEP_DEFAULT));
		foreach (edge_cvs[i])
			send_cv(edge_cvs[i]);
		finish_phase();

		// All-ones words. The knob keeps its low 13 bits (about 2 V, so larger cv words
		// clamp high), and the step is far past the nominal maximum. At the high clamp
		// the increment then exceeds a whole cycle and must wrap modulo one cycle.
		set_regs('1, '1);
		send_cv(-17'sd8191);
		send_cv(17'sd12288);
		send_cv(17'h10000);
		send_cv(17'h0FFFF);
		finish_phase();

		// Random phases. The first three use fixed register values, and the
		// rest draw them at random. Phase 1 carries the long receiver hold-off.
		// Phase 4 runs without gaps on either side. Phase 5 stops halfway until
		// all of its results are back.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_regs('0, CFG_W'(STEP_DEFAULT));
				1: set_regs(CFG_W'(KNOB_ONE_VOLT), CFG_W'(STEP_RANGE_TOP));
				2: set_regs(CFG_W'(KNOB_ONE_VOLT), CFG_W'(1));
				default: set_regs(random_knob_word(), random_step_word());
			endcase
			bursting = (p == 4);
			if (p == 1)
				hold_wave = 1'b1;
			half = WORDS_PER_PHASE / 2;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (p == 5 && n == half)
					finish_phase();
				send_cv(random_cv());
			end
			finish_phase();
		end
		bursting = 1'b0;

		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (pending != 0)
				$error("%0d wave words never arrived", pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Far beyond the slowest legitimate run, even with every gap at its longest.
	initial begin : watchdog
		#12ms;
		$error("Run timed out before every wave word arrived.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
design/eps_pkg.sv
design/eps_if.sv
design/eps_ctrl.sv
design/eps_dp.sv
design/exp_pitch_square_oscillator_top.sv
design/eps_checker.sv
verif/eps_square_checker.sv
verif/tb.sv
